>>> rtl/dtb_pkg.sv
// Shared types, codes and helpers for the depth test buffer.
// Used by dtb_front, dtb_queue, dtb_back and depth_test_buffer_top.
// Has no dependencies.
package dtb_pkg;

  // Configuration port.
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_DEPTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_FUNC    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HEIGHT = 2'd3;

  // Item actions.
  localparam logic ACT_TEST  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Depth compare functions: fragment depth F against stored depth S.
  localparam logic [2:0] FUNC_NEVER    = 3'd0;
  localparam logic [2:0] FUNC_LESS     = 3'd1;
  localparam logic [2:0] FUNC_EQUAL    = 3'd2;
  localparam logic [2:0] FUNC_LEQUAL   = 3'd3;
  localparam logic [2:0] FUNC_GREATER  = 3'd4;
  localparam logic [2:0] FUNC_NOTEQUAL = 3'd5;
  localparam logic [2:0] FUNC_GEQUAL   = 3'd6;
  localparam logic [2:0] FUNC_ALWAYS   = 3'd7;

  // Reset values of the registers.
  localparam logic [23:0] CLEAR_DEPTH_RST = 24'hFFFFFF;
  localparam logic [2:0]  DEPTH_FUNC_RST  = FUNC_ALWAYS;
  localparam logic [8:0]  ACTIVE_DIM_RST  = 9'd256;

  // Width for window dimensions; holds store sizes up to 8191.
  localparam int DIM_W = 13;

  // Skid queue between front and back.
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [23:0] clear_depth;
    logic [2:0]  depth_func;
    logic [8:0]  active_width;
    logic [8:0]  active_height;
  } cfg_t;

  typedef struct packed {
    logic passed;
    logic outside;
  } result_t;

  // Active dimension clipped to the size of the store.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [8:0] act,
                                               input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] act_ext;
    act_ext = DIM_W'(act);
    return (act_ext > max_dim) ? max_dim : act_ext;
  endfunction

endpackage

>>> rtl/dtb_front.sv
// Front end of the depth test buffer: accepts items and classifies them.
// Produces a packed queue entry; depends on dtb_pkg.
module dtb_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24,
  parameter int XW         = 8,
  parameter int YW         = 8
) (
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic signed [9:0]           pos_x,
  input  logic signed [9:0]           pos_y,
  input  logic [23:0]                 frag_depth,
  input  dtb_pkg::cfg_t               cfg,
  input  logic                        q_full,
  input  logic                        init_busy,
  output logic                        q_push,
  output logic [2+YW+XW+DEPTH_BITS-1:0] q_wdata
);

  logic [dtb_pkg::DIM_W-1:0] eff_w;
  logic [dtb_pkg::DIM_W-1:0] eff_h;
  logic [dtb_pkg::DIM_W-1:0] x_ext;
  logic [dtb_pkg::DIM_W-1:0] y_ext;
  logic                      outside;

  assign eff_w = dtb_pkg::eff_dim(cfg.active_width, dtb_pkg::DIM_W'(MAX_WIDTH));
  assign eff_h = dtb_pkg::eff_dim(cfg.active_height, dtb_pkg::DIM_W'(MAX_HEIGHT));

  assign x_ext = dtb_pkg::DIM_W'($unsigned(pos_x));
  assign y_ext = dtb_pkg::DIM_W'($unsigned(pos_y));

  // Negative coordinates are outside; the range compares only matter when
  // the coordinate is non-negative.
  assign outside = pos_x[9] || pos_y[9] || (x_ext >= eff_w) || (y_ext >= eff_h);

  assign in_stall = rst || q_full || init_busy;
  assign q_push   = in_valid && !in_stall;

  assign q_wdata = {action,
                    (action == dtb_pkg::ACT_TEST) && outside,
                    YW'($unsigned(pos_y)),
                    XW'($unsigned(pos_x)),
                    DEPTH_BITS'(frag_depth)};

endmodule

>>> rtl/dtb_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on dtb_pkg for its depth.
module dtb_queue #(
  parameter int WIDTH = 44
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]            entries [0:dtb_pkg::QUEUE_DEPTH-1];
  logic [dtb_pkg::QUEUE_AW-1:0] wptr;
  logic [dtb_pkg::QUEUE_AW-1:0] rptr;
  logic [dtb_pkg::QUEUE_AW:0]   count;

  assign full  = (count == (dtb_pkg::QUEUE_AW + 1)'(dtb_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/dtb_back.sv
// Back end of the depth test buffer: depth store, test, clear sweep and
// the output register. Depends on dtb_pkg.
module dtb_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24,
  parameter int XW         = 8,
  parameter int YW         = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dtb_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  logic [2+YW+XW+DEPTH_BITS-1:0] q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dtb_pkg::result_t              result,
  output logic                          init_busy
);

  localparam int AW = XW + YW;
  localparam int DW = dtb_pkg::DIM_W;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [XW-1:0]         cx;
  logic [XW-1:0]         cx_next;
  logic [YW-1:0]         cy;
  logic [YW-1:0]         cy_next;
  logic [XW-1:0]         cx_adv;
  logic [YW-1:0]         cy_adv;

  logic [DEPTH_BITS-1:0] store [0:(1 << AW)-1];
  logic [DEPTH_BITS-1:0] rd_data;
  logic                  rd_en;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdata;

  logic [AW-1:0]         cmp_addr;
  logic [DEPTH_BITS-1:0] cmp_depth;
  logic                  depth_ok;

  logic                  e_action;
  logic                  e_outside;
  logic [YW-1:0]         e_y;
  logic [XW-1:0]         e_x;
  logic [DEPTH_BITS-1:0] e_depth;

  logic [DW-1:0]         eff_w;
  logic [DW-1:0]         eff_h;
  logic [DW-1:0]         lim_w;
  logic [DW-1:0]         lim_h;
  logic                  zero_area;
  logic                  last_col;
  logic                  last;
  logic [DEPTH_BITS-1:0] sweep_data;

  logic                  out_free;
  logic                  load;
  dtb_pkg::result_t      load_val;

  assign {e_action, e_outside, e_y, e_x, e_depth} = q_rdata;

  assign eff_w     = dtb_pkg::eff_dim(cfg.active_width, DW'(MAX_WIDTH));
  assign eff_h     = dtb_pkg::eff_dim(cfg.active_height, DW'(MAX_HEIGHT));
  assign zero_area = (eff_w == '0) || (eff_h == '0);

  // The power-up sweep covers MAX_WIDTH by MAX_HEIGHT entries; a clear covers the active area.
  assign lim_w      = (state == S_INIT) ? DW'(MAX_WIDTH - 1) : eff_w - 1'b1;
  assign lim_h      = (state == S_INIT) ? DW'(MAX_HEIGHT - 1) : eff_h - 1'b1;
  assign last_col   = (DW'(cx) == lim_w);
  assign last       = last_col && (DW'(cy) == lim_h);
  assign cx_adv     = last_col ? '0 : cx + 1'b1;
  assign cy_adv     = last_col ? cy + 1'b1 : cy;
  assign sweep_data = (state == S_INIT) ? '1 : DEPTH_BITS'(cfg.clear_depth);

  assign out_free  = !out_valid || !out_stall;
  assign init_busy = (state == S_INIT);

  always_comb begin
    unique case (cfg.depth_func)
      dtb_pkg::FUNC_NEVER:    depth_ok = 1'b0;
      dtb_pkg::FUNC_LESS:     depth_ok = cmp_depth < rd_data;
      dtb_pkg::FUNC_EQUAL:    depth_ok = cmp_depth == rd_data;
      dtb_pkg::FUNC_LEQUAL:   depth_ok = cmp_depth <= rd_data;
      dtb_pkg::FUNC_GREATER:  depth_ok = cmp_depth > rd_data;
      dtb_pkg::FUNC_NOTEQUAL: depth_ok = cmp_depth != rd_data;
      dtb_pkg::FUNC_GEQUAL:   depth_ok = cmp_depth >= rd_data;
      dtb_pkg::FUNC_ALWAYS:   depth_ok = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    cx_next    = cx;
    cy_next    = cy;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = {cy, cx};
    mem_wdata  = sweep_data;
    load       = 1'b0;
    load_val   = '0;
    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        if (last) begin
          cx_next    = '0;
          cy_next    = '0;
          state_next = S_IDLE;
        end else begin
          cx_next = cx_adv;
          cy_next = cy_adv;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          if (e_action == dtb_pkg::ACT_CLEAR) begin
            if (zero_area) begin
              if (out_free) begin
                q_pop = 1'b1;
                load  = 1'b1;
              end
            end else begin
              q_pop      = 1'b1;
              state_next = S_CLR;
            end
          end else if (e_outside) begin
            if (out_free) begin
              q_pop            = 1'b1;
              load             = 1'b1;
              load_val.outside = 1'b1;
            end
          end else begin
            q_pop      = 1'b1;
            rd_en      = 1'b1;
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (out_free) begin
          load            = 1'b1;
          load_val.passed = depth_ok;
          mem_we          = depth_ok;
          mem_waddr       = cmp_addr;
          mem_wdata       = cmp_depth;
          state_next      = S_IDLE;
        end
      end
      S_CLR: begin
        if (!last) begin
          mem_we  = 1'b1;
          cx_next = cx_adv;
          cy_next = cy_adv;
        end else if (out_free) begin
          mem_we     = 1'b1;
          load       = 1'b1;
          cx_next    = '0;
          cy_next    = '0;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cx        <= '0;
      cy        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cx    <= cx_next;
      cy    <= cy_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_val;
    end
    if (rd_en) begin
      cmp_addr  <= {e_y, e_x};
      cmp_depth <= e_depth;
    end
  end

  // Depth store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= store[{e_y, e_x}];
    end
  end

endmodule

>>> rtl/depth_test_buffer_top.sv
// Top level of the depth test buffer: configuration registers, front end,
// queue and back end. Depends on dtb_pkg, dtb_front, dtb_queue, dtb_back.
//
// Usage. Fragment and clear items arrive on the input channel (in_valid,
// in_stall); a transfer happens at a rising edge with in_valid high and
// in_stall low. Every item gives exactly one result on the output channel
// (out_valid, out_stall) carrying passed and outside, in item order.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while no item is in flight, as
// the block itself does not enforce this. An outside fragment passes the
// queue and the output register; an inside one also passes the store read
// register ahead of the compare and write-back. The back end alone uses the
// store: an outside fragment in the idle state, an inside one in the idle and
// compare states, a clear in the idle state, then one active entry per cycle
// in the clear state (none for an empty area), the last when output is free.
// A two-entry queue lets the input keep transferring while the back end
// works or the output register waits on a stalled receiver; when the
// receiver stalls, the result holds and the queue fills, then in_stall rises.
// Reset: the registers return to their defaults and the store is swept to
// far depth, one entry a cycle, over MAX_WIDTH * MAX_HEIGHT entries (65536 with
// the defaults); in_stall stays high for the sweep, configuration is taken.
module depth_test_buffer_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic signed [9:0]                 pos_x,
  input  logic signed [9:0]                 pos_y,
  input  logic [23:0]                       frag_depth,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              passed,
  output logic                              outside,
  input  logic                              cfg_write,
  input  logic [dtb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dtb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // The store row pitch is the smallest power of two not below MAX_WIDTH, so the
  // entry address is just the row and column bits side by side.
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW = 2 + YW + XW + DEPTH_BITS;

  dtb_pkg::cfg_t    cfg;
  dtb_pkg::result_t result;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [EW-1:0]    q_wdata;
  logic [EW-1:0]    q_rdata;
  logic             init_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clear_depth   <= dtb_pkg::CLEAR_DEPTH_RST;
      cfg.depth_func    <= dtb_pkg::DEPTH_FUNC_RST;
      cfg.active_width  <= dtb_pkg::ACTIVE_DIM_RST;
      cfg.active_height <= dtb_pkg::ACTIVE_DIM_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dtb_pkg::REG_CLEAR_DEPTH:   cfg.clear_depth   <= cfg_data;
        dtb_pkg::REG_DEPTH_FUNC:    cfg.depth_func    <= cfg_data[2:0];
        dtb_pkg::REG_ACTIVE_WIDTH:  cfg.active_width  <= cfg_data[8:0];
        dtb_pkg::REG_ACTIVE_HEIGHT: cfg.active_height <= cfg_data[8:0];
      endcase
    end
  end

  dtb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS),
    .XW         (XW),
    .YW         (YW)
  ) u_front (
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .frag_depth (frag_depth),
    .cfg        (cfg),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  dtb_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  dtb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS),
    .XW         (XW),
    .YW         (YW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result),
    .init_busy  (init_busy)
  );

  assign passed  = result.passed;
  assign outside = result.outside;

  // The queue can never be full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // A fragment outside the active area never passes.
  a_outside_fails: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(passed && outside))
    else $error("result is both passed and outside");

  // No result is produced while the store is being swept after reset.
  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !out_valid)
    else $error("result presented during the power-up sweep");

  // A pushed entry is still waiting or being worked on in the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> !q_empty)
    else $error("queue entry lost after push");

endmodule
